/* rtl/wwmd_pkg.sv */
package wwmd_pkg;

  localparam int unsigned Q_W            = 32;
  localparam int unsigned SUM_W          = 43;
  localparam int unsigned DIV_W          = SUM_W + 1;
  localparam int unsigned SCALE_W        = 24;
  localparam int unsigned PROD_W         = Q_W + SCALE_W;
  localparam int unsigned FRAC_W         = 16;
  localparam int unsigned MASK_W         = 6;
  localparam int unsigned CHANNELS       = 6;
  localparam int unsigned NUM_FORCE      = 3;
  localparam int unsigned STALE_W        = 16;
  localparam int unsigned STEP_W         = $clog2(DIV_W);
  localparam int unsigned MAX_WINDOW_DEF = 1024;
  localparam int unsigned ADDR_W         = 3;
  localparam int unsigned DATA_W         = 32;

  localparam logic [SCALE_W-1:0] SCALE_UNITY = SCALE_W'(1 << FRAC_W);
  localparam logic [SCALE_W-1:0] SCALE_RST   = SCALE_W'(1 << FRAC_W);
  localparam logic [PROD_W-1:0]  ROUND_HALF  = PROD_W'(1 << (FRAC_W - 1));
  localparam logic [Q_W-1:0]     Q_MAX_V     = {1'b0, {(Q_W - 1){1'b1}}};
  localparam logic [Q_W-1:0]     Q_MIN_V     = {1'b1, {(Q_W - 1){1'b0}}};
  localparam logic [SUM_W-1:0]   SUM_MAX_V   = {1'b0, {(SUM_W - 1){1'b1}}};
  localparam logic [SUM_W-1:0]   SUM_MIN_V   = {1'b1, {(SUM_W - 1){1'b0}}};

  typedef enum logic {
    FUNC_SAMPLE = 1'b0,
    FUNC_DRAIN  = 1'b1
  } func_e;

  typedef enum logic {
    REG_MASK  = 1'b0,
    REG_SCALE = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ROUND,
    ST_ACC,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } state_e;

  typedef enum logic [2:0] {
    LOP_IDLE,
    LOP_LOAD_SMP,
    LOP_MUL,
    LOP_ROUND,
    LOP_ACC,
    LOP_LOAD_DRN,
    LOP_DIV,
    LOP_FIN
  } lane_op_e;

  typedef struct packed {
    lane_op_e           op;
    logic               negate;
    logic [SCALE_W-1:0] scale;
  } lane_ctrl_t;

  // apply sign to a magnitude and clamp to the signed q16.16 range
  function automatic logic [Q_W-1:0] sat_signed(input logic neg, input logic [DIV_W-1:0] mag);
    logic [Q_W-1:0] r;
    if (!neg) begin
      r = (mag > {{(DIV_W - Q_W){1'b0}}, Q_MAX_V}) ? Q_MAX_V : mag[Q_W-1:0];
    end else begin
      r = (mag > {{(DIV_W - Q_W){1'b0}}, Q_MIN_V}) ? Q_MIN_V :
          (Q_W'(~mag[Q_W-1:0]) + Q_W'(1));
    end
    return r;
  endfunction

endpackage

/* rtl/wwmd_ifs.sv */
interface wwmd_in_if;
  import wwmd_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  func;
  logic signed [Q_W-1:0] force_x_in;
  logic signed [Q_W-1:0] force_y_in;
  logic signed [Q_W-1:0] force_z_in;
  logic signed [Q_W-1:0] torque_x_in;
  logic signed [Q_W-1:0] torque_y_in;
  logic signed [Q_W-1:0] torque_z_in;
  logic                  link_up;

  modport source (
    output valid, func, force_x_in, force_y_in, force_z_in,
           torque_x_in, torque_y_in, torque_z_in, link_up,
    input  ready
  );

  modport sink (
    input  valid, func, force_x_in, force_y_in, force_z_in,
           torque_x_in, torque_y_in, torque_z_in, link_up,
    output ready
  );
endinterface

interface wwmd_out_if;
  import wwmd_pkg::*;

  logic                  valid;
  logic                  ready;
  logic signed [Q_W-1:0] mean_fx;
  logic signed [Q_W-1:0] mean_fy;
  logic signed [Q_W-1:0] mean_fz;
  logic signed [Q_W-1:0] mean_mx;
  logic signed [Q_W-1:0] mean_my;
  logic signed [Q_W-1:0] mean_mz;
  logic                  fresh;
  logic [STALE_W-1:0]    stale_count;

  modport source (
    output valid, mean_fx, mean_fy, mean_fz, mean_mx, mean_my, mean_mz,
           fresh, stale_count,
    input  ready
  );

  modport sink (
    input  valid, mean_fx, mean_fy, mean_fz, mean_mx, mean_my, mean_mz,
           fresh, stale_count,
    output ready
  );
endinterface

/* rtl/wwmd_lane.sv */
module wwmd_lane #(
  parameter int unsigned CNT_W = $clog2(wwmd_pkg::MAX_WINDOW_DEF + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  wwmd_pkg::lane_ctrl_t       ctrl_i,
  input  logic [wwmd_pkg::Q_W-1:0]   smp_i,
  input  logic [CNT_W-1:0]           den_i,
  output logic [wwmd_pkg::Q_W-1:0]   held_o
);
  import wwmd_pkg::*;

  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [Q_W-1:0]    held_q, held_d;
  logic              sgn_q, sgn_d;
  logic [Q_W-1:0]    mag_q, mag_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic [Q_W-1:0]    val_q, val_d;
  logic [DIV_W-1:0]  num_q, num_d;
  logic [CNT_W-1:0]  rem_q, rem_d;

  logic [Q_W-1:0]    neg_val;
  logic [Q_W:0]      mul_add;
  logic [PROD_W-1:0] rnd;
  logic [DIV_W-1:0]  sum_ext;
  logic [DIV_W-1:0]  sum_abs;
  logic [DIV_W-1:0]  acc_sum;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    trial_sub;
  logic              ge;

  always_comb begin
    // negate with saturation of the most negative value
    if (ctrl_i.negate) begin
      neg_val = (smp_i == Q_MIN_V) ? Q_MAX_V : (Q_W'(~smp_i) + Q_W'(1));
    end else begin
      neg_val = smp_i;
    end
    mul_add   = {1'b0, prod_q[PROD_W-1:SCALE_W]} + {1'b0, (prod_q[0] ? mag_q : '0)};
    rnd       = prod_q + ROUND_HALF;
    sum_ext   = {sum_q[SUM_W-1], sum_q};
    sum_abs   = sum_q[SUM_W-1] ? (DIV_W'(~sum_ext) + DIV_W'(1)) : sum_ext;
    acc_sum   = sum_ext + {{(DIV_W - Q_W){val_q[Q_W-1]}}, val_q};
    trial     = {rem_q, num_q[DIV_W-1]};
    trial_sub = trial - {1'b0, den_i};
    ge        = (trial >= {1'b0, den_i});
  end

  always_comb begin
    sum_d  = sum_q;
    held_d = held_q;
    sgn_d  = sgn_q;
    mag_d  = mag_q;
    prod_d = prod_q;
    val_d  = val_q;
    num_d  = num_q;
    rem_d  = rem_q;
    unique case (ctrl_i.op)
      LOP_IDLE: begin
      end
      LOP_LOAD_SMP: begin
        sgn_d  = neg_val[Q_W-1];
        mag_d  = neg_val[Q_W-1] ? (Q_W'(~neg_val) + Q_W'(1)) : neg_val;
        prod_d = {{Q_W{1'b0}}, ctrl_i.scale};
      end
      LOP_MUL: begin
        prod_d = {mul_add, prod_q[SCALE_W-1:1]};
      end
      LOP_ROUND: begin
        val_d = sat_signed(sgn_q, DIV_W'(rnd[PROD_W-1:FRAC_W]));
      end
      LOP_ACC: begin
        if (acc_sum[DIV_W-1] != acc_sum[SUM_W-1]) begin
          sum_d = acc_sum[DIV_W-1] ? SUM_MIN_V : SUM_MAX_V;
        end else begin
          sum_d = acc_sum[SUM_W-1:0];
        end
      end
      LOP_LOAD_DRN: begin
        sgn_d = sum_q[SUM_W-1];
        num_d = sum_abs + DIV_W'(den_i >> 1);
        rem_d = '0;
        sum_d = '0;
      end
      LOP_DIV: begin
        rem_d = ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
        num_d = {num_q[DIV_W-2:0], ge};
      end
      LOP_FIN: begin
        held_d = sat_signed(sgn_q, num_q);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      held_q <= '0;
    end else begin
      sum_q  <= sum_d;
      held_q <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sgn_q  <= sgn_d;
    mag_q  <= mag_d;
    prod_q <= prod_d;
    val_q  <= val_d;
    num_q  <= num_d;
    rem_q  <= rem_d;
  end

  assign held_o = held_q;

endmodule

/* rtl/wrench_window_mean_decimator_unit.sv */
// channel   dir  handshake     word
// in_ch     in   valid/ready   func, three forces, three torques, link_up
// out_ch    out  valid/ready   six means, fresh, stale_count
// apb       in   psel/penable  channel_negate_mask at 0x0, torque_scale at 0x4
//
// a sample runs load, 24 bit-serial multiply steps, round, accumulate
// a fresh drain loads, runs the restoring divider in each lane over all 44 quotient bits, then finishes
// a stale drain goes straight to the output state, a sample into a full window is dropped in idle
// the result sits in an output register, so the next word is taken while it waits
// a drain holds in its last cycle while the previous result is still not taken
// reset is asynchronous active low and clears sums, counters and the held wrench
module wrench_window_mean_decimator_unit #(
  parameter int unsigned MAX_WINDOW = wwmd_pkg::MAX_WINDOW_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  wwmd_in_if.sink                       in_ch,
  wwmd_out_if.source                    out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wwmd_pkg::ADDR_W-1:0]   paddr,
  input  logic [wwmd_pkg::DATA_W-1:0]   pwdata,
  output logic [wwmd_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import wwmd_pkg::*;

  localparam int unsigned      CNT_W    = $clog2(MAX_WINDOW + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_WINDOW);

  logic [MASK_W-1:0]  mask_q;
  logic [SCALE_W-1:0] scale_q;
  reg_idx_e           reg_sel;
  logic               cfg_we;

  state_e             state_q, state_d;
  logic [STEP_W-1:0]  step_q, step_d;
  lane_op_e           lane_op;
  logic [CNT_W-1:0]   count_q;
  logic [CNT_W-1:0]   div_q;
  logic [CNT_W-1:0]   den;
  logic [STALE_W-1:0] stale_q;
  logic               fresh_q;
  logic               in_acc;
  logic               is_drain;
  logic               do_fresh;
  logic               out_load;

  logic               out_valid_q;
  logic [Q_W-1:0]     out_mean_q [CHANNELS];
  logic               out_fresh_q;
  logic [STALE_W-1:0] out_stale_q;

  lane_ctrl_t         ctrl [CHANNELS];
  logic [Q_W-1:0]     smp  [CHANNELS];
  logic [Q_W-1:0]     held [CHANNELS];

  // configuration port
  assign reg_sel = reg_idx_e'(paddr[ADDR_W-1]);
  assign cfg_we  = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_comb begin
    unique case (reg_sel)
      REG_MASK:  prdata = DATA_W'(mask_q);
      REG_SCALE: prdata = DATA_W'(scale_q);
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q  <= '0;
      scale_q <= SCALE_RST;
    end else if (cfg_we) begin
      unique case (reg_sel)
        REG_MASK:  mask_q  <= pwdata[MASK_W-1:0];
        REG_SCALE: scale_q <= pwdata[SCALE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer
  assign in_ch.ready = (state_q == ST_IDLE);
  assign in_acc      = in_ch.valid & in_ch.ready;
  assign is_drain    = (in_ch.func == FUNC_DRAIN);
  assign do_fresh    = (count_q != '0) & in_ch.link_up;
  assign out_load    = (state_q == ST_OUT) & (~out_valid_q | out_ch.ready);

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    lane_op = LOP_IDLE;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          step_d = '0;
          if (is_drain) begin
            lane_op = LOP_LOAD_DRN;
            state_d = do_fresh ? ST_DIV : ST_OUT;
          end else if (count_q < CNT_FULL) begin
            lane_op = LOP_LOAD_SMP;
            state_d = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        lane_op = LOP_MUL;
        step_d  = step_q + STEP_W'(1);
        if (step_q == STEP_W'(SCALE_W - 1)) begin
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        lane_op = LOP_ROUND;
        state_d = ST_ACC;
      end
      ST_ACC: begin
        lane_op = LOP_ACC;
        state_d = ST_IDLE;
      end
      ST_DIV: begin
        lane_op = LOP_DIV;
        step_d  = step_q + STEP_W'(1);
        if (step_q == STEP_W'(DIV_W - 1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        lane_op = LOP_FIN;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      count_q <= '0;
      div_q   <= '0;
      stale_q <= '0;
      fresh_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (state_q == ST_ACC) begin
        count_q <= count_q + CNT_W'(1);
      end
      if (in_acc && is_drain) begin
        count_q <= '0;
        div_q   <= count_q;
        fresh_q <= do_fresh;
        if (do_fresh) begin
          stale_q <= '0;
        end else if (stale_q != {STALE_W{1'b1}}) begin
          stale_q <= stale_q + STALE_W'(1);
        end
      end
    end
  end

  // lanes
  assign smp[0] = in_ch.force_x_in;
  assign smp[1] = in_ch.force_y_in;
  assign smp[2] = in_ch.force_z_in;
  assign smp[3] = in_ch.torque_x_in;
  assign smp[4] = in_ch.torque_y_in;
  assign smp[5] = in_ch.torque_z_in;

  assign den = (state_q == ST_IDLE) ? count_q : div_q;

  for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
    assign ctrl[i].op     = lane_op;
    assign ctrl[i].negate = mask_q[i];
    assign ctrl[i].scale  = (i >= NUM_FORCE) ? scale_q : SCALE_UNITY;

    wwmd_lane #(
      .CNT_W (CNT_W)
    ) u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl[i]),
      .smp_i  (smp[i]),
      .den_i  (den),
      .held_o (held[i])
    );
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_mean_q  <= held;
      out_fresh_q <= fresh_q;
      out_stale_q <= stale_q;
    end
  end

  assign out_ch.valid       = out_valid_q;
  assign out_ch.mean_fx     = out_mean_q[0];
  assign out_ch.mean_fy     = out_mean_q[1];
  assign out_ch.mean_fz     = out_mean_q[2];
  assign out_ch.mean_mx     = out_mean_q[3];
  assign out_ch.mean_my     = out_mean_q[4];
  assign out_ch.mean_mz     = out_mean_q[5];
  assign out_ch.fresh       = out_fresh_q;
  assign out_ch.stale_count = out_stale_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_FULL)
    else $error("sample count beyond window");

  a_drain_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && is_drain |=> count_q == '0)
    else $error("drain did not clear sample count");

  a_fresh_stale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && out_ch.fresh |-> out_ch.stale_count == '0)
    else $error("fresh word with nonzero stale count");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> div_q != '0)
    else $error("divide by zero count");

endmodule

/* verif/tb_top.sv */
module tb_top;
  import wwmd_pkg::*;

  localparam longint Q_HI = 64'sd2147483647;
  localparam longint Q_LO = -64'sd2147483648;
  localparam longint SUM_HI = 64'sd4398046511103;
  localparam longint SUM_LO = -64'sd4398046511104;
  localparam logic [31:0] QP = 32'h7fff_ffff;
  localparam logic [31:0] QN = 32'h8000_0000;
  localparam logic [31:0] M1 = 32'hffff_ffff;
  localparam logic [31:0] M2 = 32'hffff_fffe;
  localparam int SETTLE_CYC = 64;
  localparam int RAND_WORDS = 500;
  localparam int PHASE_WORDS = 200;

  typedef struct packed {
    func_e            func;
    logic [5:0][31:0] ch;
    logic             link;
  } ft_word_t;

  typedef struct packed {
    logic [5:0][31:0] mean;
    logic             fresh;
    logic [15:0]      stale;
  } wrench_res_t;

  typedef struct packed {
    ft_word_t           w;
    int                 reps;
    logic [MASK_W-1:0]  mask;
    logic [SCALE_W-1:0] scale;
    logic               typed;
    wrench_res_t        want;
  } dir_row_t;

  logic               clk;
  logic               rst_n;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [DATA_W-1:0]  pwdata;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  wwmd_in_if  in_if ();
  wwmd_out_if out_if ();

  wrench_window_mean_decimator_unit dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_ch   (in_if),
    .out_ch  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor state
  logic [MASK_W-1:0]  neg_mask;
  logic [SCALE_W-1:0] tq_scale;
  longint             win_sum [CHANNELS];
  int unsigned        win_count;
  logic [31:0]        held [CHANNELS];
  logic [15:0]        stale_cnt;

  wrench_res_t pending_means [$];
  int          mismatch_cnt;
  logic        drv_typed;
  wrench_res_t drv_want;
  bit          calm;
  string       ch_name [CHANNELS] = '{"mean_fx", "mean_fy", "mean_fz",
                                      "mean_mx", "mean_my", "mean_mz"};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200000000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // nearest, ties away from zero
  function automatic longint round_div(input longint num, input longint den);
    bit     neg;
    longint mag;
    longint q;
    neg = num < 0;
    mag = neg ? -num : num;
    q = (mag + den / 2) / den;
    return neg ? -q : q;
  endfunction

  function automatic void predict_wrench(input ft_word_t w, output bit emits,
                                         output wrench_res_t r);
    longint v;
    emits = 1'b0;
    r = '0;
    if (w.func == FUNC_SAMPLE) begin
      if (win_count >= MAX_WINDOW_DEF) return;
      for (int i = 0; i < CHANNELS; i++) begin
        v = longint'(signed'(w.ch[i]));
        if (neg_mask[i]) v = clip(-v, Q_LO, Q_HI);
        if (i >= NUM_FORCE) v = clip(round_div(v * longint'(tq_scale), 64'd65536), Q_LO, Q_HI);
        win_sum[i] = clip(win_sum[i] + v, SUM_LO, SUM_HI);
      end
      win_count++;
      return;
    end
    if (win_count > 0 && w.link) begin
      for (int i = 0; i < CHANNELS; i++) begin
        held[i] = 32'(clip(round_div(win_sum[i], longint'(win_count)), Q_LO, Q_HI));
      end
      stale_cnt = '0;
      r.fresh = 1'b1;
    end else begin
      if (stale_cnt != 16'hffff) stale_cnt++;
      r.fresh = 1'b0;
    end
    for (int i = 0; i < CHANNELS; i++) begin
      r.mean[i] = held[i];
      win_sum[i] = 0;
    end
    r.stale = stale_cnt;
    win_count = 0;
    emits = 1'b1;
  endfunction

  always @(posedge clk) begin : scoreboard
    ft_word_t         w;
    bit               emits;
    wrench_res_t      r;
    wrench_res_t      e;
    logic [5:0][31:0] got;
    if (rst_n && in_if.valid && in_if.ready) begin
      w.func  = func_e'(in_if.func);
      w.ch    = {in_if.torque_z_in, in_if.torque_y_in, in_if.torque_x_in,
                 in_if.force_z_in, in_if.force_y_in, in_if.force_x_in};
      w.link  = in_if.link_up;
      predict_wrench(w, emits, r);
      if (emits) pending_means.push_back(drv_typed ? drv_want : r);
    end
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_means.size() == 0) begin
        $display("%0t: unexpected word fresh %b stale %0d", $time, out_if.fresh,
                 out_if.stale_count);
        mismatch_cnt++;
      end else begin
        e = pending_means.pop_front();
        got = {out_if.mean_mz, out_if.mean_my, out_if.mean_mx,
               out_if.mean_fz, out_if.mean_fy, out_if.mean_fx};
        for (int i = 0; i < CHANNELS; i++) begin
          if (got[i] !== e.mean[i]) begin
            $display("%0t: %s expected %h actual %h", $time, ch_name[i], e.mean[i], got[i]);
            mismatch_cnt++;
          end
        end
        if (out_if.fresh !== e.fresh) begin
          $display("%0t: fresh expected %b actual %b", $time, e.fresh, out_if.fresh);
          mismatch_cnt++;
        end
        if (out_if.stale_count !== e.stale) begin
          $display("%0t: stale_count expected %0d actual %0d", $time, e.stale,
                   out_if.stale_count);
          mismatch_cnt++;
        end
      end
    end
  end

  function automatic int gap_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin : sink_stall
    int stall;
    stall = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        stall--;
      end else begin
        out_if.ready <= 1'b1;
        if ($urandom_range(0, 7) == 0) stall = gap_len();
      end
    end
  end

  task automatic drive_word(input ft_word_t w, input logic typed, input wrench_res_t want);
    int g;
    g = gap_len();
    repeat (g) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
    end
    @(negedge clk);
    in_if.valid       <= 1'b1;
    in_if.func        <= w.func;
    in_if.force_x_in  <= w.ch[0];
    in_if.force_y_in  <= w.ch[1];
    in_if.force_z_in  <= w.ch[2];
    in_if.torque_x_in <= w.ch[3];
    in_if.torque_y_in <= w.ch[4];
    in_if.torque_z_in <= w.ch[5];
    in_if.link_up     <= w.link;
    drv_typed         <= typed;
    drv_want          <= want;
    do @(posedge clk); while (!in_if.ready);
  endtask

  // wait for every result, then let an in-flight sample finish
  task automatic quiesce();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic cfg_write(input reg_idx_e idx, input logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= ADDR_W'(4 * idx);
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_MASK) neg_mask = val[MASK_W-1:0];
    else tq_scale = val[SCALE_W-1:0];
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== val) begin
      $display("%0t: readback of %s expected %h actual %h", $time, idx.name(), val, prdata);
      mismatch_cnt++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_config(input logic [MASK_W-1:0] m, input logic [SCALE_W-1:0] s);
    cfg_write(REG_MASK, 32'(m));
    cfg_write(REG_SCALE, 32'(s));
  endtask

  function automatic dir_row_t mk(input func_e f, input logic [31:0] a, b, c, d, e, g,
                                  input logic link, input int reps,
                                  input logic [MASK_W-1:0] mask,
                                  input logic [SCALE_W-1:0] scale);
    dir_row_t r;
    r = '0;
    r.w.func = f;
    r.w.ch   = {g, e, d, c, b, a};
    r.w.link = link;
    r.reps   = reps;
    r.mask   = mask;
    r.scale  = scale;
    return r;
  endfunction

  function automatic dir_row_t mk_exp(input dir_row_t r, input logic [31:0] a, b, c, d, e, g,
                                      input logic fresh, input logic [15:0] stale);
    r.typed      = 1'b1;
    r.want.mean  = {g, e, d, c, b, a};
    r.want.fresh = fresh;
    r.want.stale = stale;
    return r;
  endfunction

  function automatic logic [31:0] rand_q();
    case ($urandom_range(0, 7))
      0: return QP;
      1: return QN;
      2: return '0;
      3: return $urandom_range(0, 16) - 8;
      4: return ($urandom_range(0, 8) - 4) << FRAC_W;
      default: return $urandom();
    endcase
  endfunction

  function automatic ft_word_t rand_word(input func_e f);
    ft_word_t w;
    w.func = f;
    for (int i = 0; i < CHANNELS; i++) w.ch[i] = rand_q();
    w.link = 1'($urandom_range(0, 1));
    return w;
  endfunction

  initial begin : stimulus
    dir_row_t rows [$];
    ft_word_t w;
    int       sent;
    int       since;
    int       phase;
    int       win_len;
    int       r;
    int       guard;

    rst_n             = 1'b0;
    in_if.valid       <= 1'b0;
    in_if.func        <= FUNC_SAMPLE;
    in_if.force_x_in  <= '0;
    in_if.force_y_in  <= '0;
    in_if.force_z_in  <= '0;
    in_if.torque_x_in <= '0;
    in_if.torque_y_in <= '0;
    in_if.torque_z_in <= '0;
    in_if.link_up     <= 1'b0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    drv_typed         <= 1'b0;
    drv_want          <= '0;
    calm              = 1'b0;
    mismatch_cnt      = 0;
    neg_mask          = '0;
    tq_scale          = SCALE_RST;
    win_count         = 0;
    stale_cnt         = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      win_sum[i] = 0;
      held[i]    = '0;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty drains, extremes, rounding ties, held wrench on link down
    rows.push_back(mk_exp(mk(FUNC_DRAIN, 0, 0, 0, 0, 0, 0, 1, 1, 0, 65536),
                          0, 0, 0, 0, 0, 0, 0, 1));
    rows.push_back(mk_exp(mk(FUNC_DRAIN, QP, QP, QP, QP, QP, QP, 0, 1, 0, 65536),
                          0, 0, 0, 0, 0, 0, 0, 2));
    rows.push_back(mk(FUNC_SAMPLE, QP, QP, QP, QP, QP, QP, 0, 1, 0, 65536));
    rows.push_back(mk_exp(mk(FUNC_DRAIN, 0, 0, 0, 0, 0, 0, 1, 1, 0, 65536),
                          QP, QP, QP, QP, QP, QP, 1, 0));
    rows.push_back(mk(FUNC_SAMPLE, QN, QN, QN, QN, QN, QN, 1, 1, 0, 65536));
    rows.push_back(mk_exp(mk(FUNC_DRAIN, 0, 0, 0, 0, 0, 0, 1, 1, 0, 65536),
                          QN, QN, QN, QN, QN, QN, 1, 0));
    rows.push_back(mk(FUNC_SAMPLE, 1, M1, 3, 0, 0, 0, 0, 1, 0, 65536));
    rows.push_back(mk(FUNC_SAMPLE, 2, M2, 0, 1, M1, 0, 1, 1, 0, 65536));
    rows.push_back(mk_exp(mk(FUNC_DRAIN, 0, 0, 0, 0, 0, 0, 1, 1, 0, 65536),
                          2, M2, 2, 1, M1, 0, 1, 0));
    rows.push_back(mk(FUNC_SAMPLE, QP, QP, QP, QP, QP, QP, 1, 1, 0, 65536));
    rows.push_back(mk_exp(mk(FUNC_DRAIN, 0, 0, 0, 0, 0, 0, 0, 1, 0, 65536),
                          2, M2, 2, 1, M1, 0, 0, 1));
    // negating the most negative value
    rows.push_back(mk(FUNC_SAMPLE, QN, QN, QN, QN, QN, QN, 1, 1, 6'h3f, 65536));
    rows.push_back(mk_exp(mk(FUNC_DRAIN, 0, 0, 0, 0, 0, 0, 1, 1, 6'h3f, 65536),
                          QP, QP, QP, QP, QP, QP, 1, 0));
    // torque scaling: half-way rounding, saturation, zero scale
    rows.push_back(mk(FUNC_SAMPLE, 0, 0, 0, 1, M1, 3, 1, 1, 0, 32768));
    rows.push_back(mk_exp(mk(FUNC_DRAIN, 0, 0, 0, 0, 0, 0, 1, 1, 0, 32768),
                          0, 0, 0, 1, M1, 2, 1, 0));
    rows.push_back(mk(FUNC_SAMPLE, QP, QN, 0, QP, QN, 1, 1, 1, 0, 24'hffffff));
    rows.push_back(mk_exp(mk(FUNC_DRAIN, 0, 0, 0, 0, 0, 0, 1, 1, 0, 24'hffffff),
                          QP, QN, 0, QP, QN, 256, 1, 0));
    rows.push_back(mk(FUNC_SAMPLE, 5, 5, 5, QP, QN, 7, 1, 1, 0, 0));
    rows.push_back(mk_exp(mk(FUNC_DRAIN, 0, 0, 0, 0, 0, 0, 1, 1, 0, 0),
                          5, 5, 5, 0, 0, 0, 1, 0));
    // full window ignores further samples
    rows.push_back(mk(FUNC_SAMPLE, 5, 5, 5, 5, 5, 5, 1, MAX_WINDOW_DEF, 0, 65536));
    rows.push_back(mk(FUNC_SAMPLE, 1000000, 1000000, 1000000, 1000000, 1000000, 1000000,
                      1, 6, 0, 65536));
    rows.push_back(mk_exp(mk(FUNC_DRAIN, 0, 0, 0, 0, 0, 0, 1, 1, 0, 65536),
                          5, 5, 5, 5, 5, 5, 1, 0));
    // empty drain after a fresh one keeps the held wrench
    rows.push_back(mk_exp(mk(FUNC_DRAIN, 0, 0, 0, 0, 0, 0, 1, 1, 0, 65536),
                          5, 5, 5, 5, 5, 5, 0, 1));
    rows.push_back(mk(FUNC_SAMPLE, 7, 7, 7, 7, 7, 7, 0, 1, 0, 65536));
    rows.push_back(mk_exp(mk(FUNC_DRAIN, 0, 0, 0, 0, 0, 0, 1, 1, 0, 65536),
                          7, 7, 7, 7, 7, 7, 1, 0));

    foreach (rows[k]) begin
      if (rows[k].mask !== neg_mask || rows[k].scale !== tq_scale) begin
        quiesce();
        set_config(rows[k].mask, rows[k].scale);
      end
      repeat (rows[k].reps) drive_word(rows[k].w, rows[k].typed, rows[k].want);
    end

    sent  = 0;
    phase = 0;
    while (sent < RAND_WORDS) begin
      quiesce();
      case (phase)
        0: set_config(6'h3f, 24'hffffff);
        1: set_config(6'h00, 24'h000000);
        2: set_config(6'h15, SCALE_UNITY);
        default: set_config(6'($urandom_range(0, 63)),
                            ($urandom_range(0, 2) == 0) ? SCALE_UNITY : 24'($urandom()));
      endcase
      since = 0;
      while (since < PHASE_WORDS && sent < RAND_WORDS) begin
        calm = ($urandom_range(0, 4) == 0);
        r = $urandom_range(0, 99);
        if (r < 10) win_len = 0;
        else if (r < 25) win_len = $urandom_range(13, 40);
        else win_len = $urandom_range(1, 12);
        repeat (win_len) drive_word(rand_word(FUNC_SAMPLE), 1'b0, '0);
        w = rand_word(FUNC_DRAIN);
        w.link = ($urandom_range(0, 5) != 0);
        drive_word(w, 1'b0, '0);
        r = win_len + 1;
        since += r;
        sent  += r;
        if ($urandom_range(0, 29) == 0) quiesce();
      end
      phase++;
    end
    calm = 1'b0;

    @(negedge clk);
    in_if.valid <= 1'b0;
    guard = 0;
    while (pending_means.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYC) @(posedge clk);
    if (pending_means.size() != 0) begin
      $display("%0t: %0d expected words never arrived", $time, pending_means.size());
      mismatch_cnt++;
    end
    if (mismatch_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
